/* rtl/core/rmq_pkg.sv */
// rmq_pkg: shared widths, constants and pipeline bus types for the
// rotation matrix to quaternion block; depends on nothing else
package rmq_pkg;

   localparam int WORD_BITS = 16;
   localparam int FRAC_BITS = 14;
   localparam int LANES     = 4;

   // signed width that holds t and every off-diagonal sum exactly
   localparam int TW  = ((FRAC_BITS + 1 > WORD_BITS) ? FRAC_BITS + 1 : WORD_BITS) + 2;
   localparam int MW  = TW;                     // magnitude width
   localparam int SQW = 2 * MW;                 // squared magnitude
   localparam int DW  = SQW + FRAC_BITS;        // dividend width
   localparam int QW  = 2 * WORD_BITS;          // quotient bits kept
   localparam int SRW = WORD_BITS + 4;          // root remainder width

   localparam logic signed [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;
   localparam logic [WORD_BITS-1:0] POS_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] NEG_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic          neg;
      logic          ovf;
      logic [MW-1:0] rem;
      logic [QW-1:0] acc;
   } div_lane_type;

   typedef struct packed {
      logic                     bad;
      logic [MW-1:0]            t;
      div_lane_type [LANES-1:0] lane;
   } div_bus_type;

   typedef struct packed {
      logic                 neg;
      logic                 ovf;
      logic [SRW-1:0]       rem;
      logic [WORD_BITS-1:0] root;
      logic [QW-1:0]        rad;
   } sqrt_lane_type;

   typedef struct packed {
      logic                      bad;
      sqrt_lane_type [LANES-1:0] lane;
   } sqrt_bus_type;

endpackage

/* rtl/core/rmq_front.sv */
// rmq_front: case choice, t and component sums, magnitudes, squaring and
// divider setup over four register stages; depends on rmq_pkg
module rmq_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  rmq_pkg::word_type  m00,
   input  rmq_pkg::word_type  m01,
   input  rmq_pkg::word_type  m02,
   input  rmq_pkg::word_type  m10,
   input  rmq_pkg::word_type  m11,
   input  rmq_pkg::word_type  m12,
   input  rmq_pkg::word_type  m20,
   input  rmq_pkg::word_type  m21,
   input  rmq_pkg::word_type  m22,
   output logic               out_valid,
   output rmq_pkg::div_bus_type out_bus
);
   import rmq_pkg::*;

   logic signed [TW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
   logic signed [TW-1:0] t1_in;
   logic signed [TW-1:0] c1_in [LANES];
   logic signed [TW-1:0] t1_ff;
   logic signed [TW-1:0] c1_ff [LANES];
   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic                 bad2_ff, bad3_ff;
   logic [MW-1:0]        t2_ff, t3_ff;
   logic                 neg2_ff [LANES];
   logic                 neg3_ff [LANES];
   logic [MW-1:0]        mag2_ff [LANES];
   logic [SQW-1:0]       sq3_ff  [LANES];
   div_bus_type          bus4_in, bus4_ff;

   assign a00 = TW'(m00);
   assign a01 = TW'(m01);
   assign a02 = TW'(m02);
   assign a10 = TW'(m10);
   assign a11 = TW'(m11);
   assign a12 = TW'(m12);
   assign a20 = TW'(m20);
   assign a21 = TW'(m21);
   assign a22 = TW'(m22);

   // branch choice on sign of m22 and the diagonal
   always_comb begin
      if (a22 < 0) begin
         if (a00 > a11) begin
            t1_in    = ONE_T + a00 - a11 - a22;
            c1_in[0] = t1_in;
            c1_in[1] = a01 + a10;
            c1_in[2] = a20 + a02;
            c1_in[3] = a12 - a21;
         end else begin
            t1_in    = ONE_T - a00 + a11 - a22;
            c1_in[0] = a01 + a10;
            c1_in[1] = t1_in;
            c1_in[2] = a12 + a21;
            c1_in[3] = a20 - a02;
         end
      end else begin
         if (a00 + a11 < 0) begin
            t1_in    = ONE_T - a00 - a11 + a22;
            c1_in[0] = a20 + a02;
            c1_in[1] = a12 + a21;
            c1_in[2] = t1_in;
            c1_in[3] = a01 - a10;
         end else begin
            t1_in    = ONE_T + a00 + a11 + a22;
            c1_in[0] = a12 - a21;
            c1_in[1] = a20 - a02;
            c1_in[2] = a01 - a10;
            c1_in[3] = t1_in;
         end
      end
   end

   // dividend is sq << FRAC_BITS; top part against t flags overflow
   always_comb begin
      logic [DW-1:0] d;
      logic [DW-1:0] hi;
      bus4_in.bad = bad3_ff;
      bus4_in.t   = t3_ff;
      for (int i = 0; i < LANES; i++) begin
         d  = {sq3_ff[i], {FRAC_BITS{1'b0}}};
         hi = d >> QW;
         bus4_in.lane[i].neg = neg3_ff[i];
         bus4_in.lane[i].ovf = (hi >= DW'(t3_ff));
         bus4_in.lane[i].rem = hi[MW-1:0];
         bus4_in.lane[i].acc = d[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff   <= t1_in;
         bad2_ff <= !(t1_ff > 0);
         t2_ff   <= MW'(t1_ff);
         bad3_ff <= bad2_ff;
         t3_ff   <= t2_ff;
         for (int i = 0; i < LANES; i++) begin
            c1_ff[i]   <= c1_in[i];
            neg2_ff[i] <= c1_ff[i] < 0;
            mag2_ff[i] <= (c1_ff[i] < 0) ? MW'(-c1_ff[i]) : MW'(c1_ff[i]);
            neg3_ff[i] <= neg2_ff[i];
            sq3_ff[i]  <= SQW'(mag2_ff[i]) * SQW'(mag2_ff[i]);
         end
         bus4_ff <= bus4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_bus   = bus4_ff;

endmodule

/* rtl/core/rmq_div_step.sv */
// rmq_div_step: one restoring division step for all four lanes, registered;
// depends on rmq_pkg
module rmq_div_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  rmq_pkg::div_bus_type in_bus,
   output logic                 out_valid,
   output rmq_pkg::div_bus_type out_bus
);
   import rmq_pkg::*;

   div_bus_type bus_in, bus_ff;
   logic        v_ff;

   always_comb begin
      logic [MW:0] r2;
      logic [MW:0] tx;
      bus_in = in_bus;
      tx     = {1'b0, in_bus.t};
      for (int i = 0; i < LANES; i++) begin
         r2 = {in_bus.lane[i].rem, in_bus.lane[i].acc[QW-1]};
         if (r2 >= tx) begin
            bus_in.lane[i].rem = MW'(r2 - tx);
            bus_in.lane[i].acc = {in_bus.lane[i].acc[QW-2:0], 1'b1};
         end else begin
            bus_in.lane[i].rem = r2[MW-1:0];
            bus_in.lane[i].acc = {in_bus.lane[i].acc[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bus_ff <= bus_in;
      end
   end

   assign out_valid = v_ff;
   assign out_bus   = bus_ff;

endmodule

/* rtl/core/rmq_sqrt_step.sv */
// rmq_sqrt_step: one digit of the integer square root for all four lanes,
// registered; depends on rmq_pkg
module rmq_sqrt_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  rmq_pkg::sqrt_bus_type in_bus,
   output logic                  out_valid,
   output rmq_pkg::sqrt_bus_type out_bus
);
   import rmq_pkg::*;

   sqrt_bus_type bus_in, bus_ff;
   logic         v_ff;

   always_comb begin
      logic [SRW-1:0] rx;
      logic [SRW-1:0] trial;
      bus_in = in_bus;
      for (int i = 0; i < LANES; i++) begin
         rx    = {in_bus.lane[i].rem[SRW-3:0], in_bus.lane[i].rad[QW-1:QW-2]};
         trial = SRW'({in_bus.lane[i].root, 2'b01});
         bus_in.lane[i].rad = {in_bus.lane[i].rad[QW-3:0], 2'b00};
         if (rx >= trial) begin
            bus_in.lane[i].rem  = rx - trial;
            bus_in.lane[i].root = {in_bus.lane[i].root[WORD_BITS-2:0], 1'b1};
         end else begin
            bus_in.lane[i].rem  = rx;
            bus_in.lane[i].root = {in_bus.lane[i].root[WORD_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bus_ff <= bus_in;
      end
   end

   assign out_valid = v_ff;
   assign out_bus   = bus_ff;

endmodule

/* rtl/core/rmq_back.sv */
// rmq_back: rounding from the root, saturation, sign and the result
// register; depends on rmq_pkg
module rmq_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  rmq_pkg::sqrt_bus_type in_bus,
   output logic                  out_valid,
   output rmq_pkg::word_type     out_q [rmq_pkg::LANES],
   output logic                  out_bad
);
   import rmq_pkg::*;

   word_type q_in [LANES];
   word_type q_ff [LANES];
   logic     bad_ff;
   logic     v_ff;

   always_comb begin
      logic [WORD_BITS:0]   np1;
      logic [WORD_BITS-1:0] n;
      for (int i = 0; i < LANES; i++) begin
         // round half up: n = (root + 1) / 2
         np1 = {1'b0, in_bus.lane[i].root} + (WORD_BITS+1)'(1);
         n   = np1[WORD_BITS:1];
         if (in_bus.bad) begin
            q_in[i] = '0;
         end else if (in_bus.lane[i].neg) begin
            if (in_bus.lane[i].ovf || n > NEG_MIN) begin
               q_in[i] = NEG_MIN;
            end else begin
               q_in[i] = -n;
            end
         end else begin
            if (in_bus.lane[i].ovf || n > POS_MAX) begin
               q_in[i] = POS_MAX;
            end else begin
               q_in[i] = n;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bad_ff <= in_bus.bad;
         for (int i = 0; i < LANES; i++) begin
            q_ff[i] <= q_in[i];
         end
      end
   end

   assign out_valid = v_ff;
   assign out_q     = q_ff;
   assign out_bad   = bad_ff;

endmodule

/* rtl/core/rotation_matrix_to_quaternion.sv */
// rotation_matrix_to_quaternion: top level of the matrix to quaternion
// pipeline; depends on rmq_pkg, rmq_front, rmq_div_step, rmq_sqrt_step, rmq_back
//
// usage
//   req channel carries one 3x3 matrix in Q2.14 per item (req_m00..req_m22);
//   an item is taken on a rising edge with req_valid high and req_stall low
//   rsp channel returns quat_x, quat_y, quat_z, quat_w (Q2.14, saturated)
//   and bad_input; taken on an edge with rsp_valid high and rsp_stall low
//   pipeline: 4 front stages, 32 divider stages, 16 square root stages and
//   1 output register lie between an accepted item and rsp_valid
//   throughput: one item per cycle unless frozen by a stall; every stage
//   retires one quotient bit or one root digit, so an item enters each cycle
//   each component is rounded from sqrt(v^2 * 2^14 / t), computed exactly
//   by a restoring divider followed by a digit-by-digit square root
//   reset: synchronous, clears every stage valid bit; payload is not reset
//   receiver stall: when the output register holds an item and rsp_stall is
//   high the whole pipeline freezes and req_stall rises; nothing is lost
//   or repeated, and the shown result holds until taken
module rotation_matrix_to_quaternion (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rmq_pkg::word_type req_m00,
   input  rmq_pkg::word_type req_m01,
   input  rmq_pkg::word_type req_m02,
   input  rmq_pkg::word_type req_m10,
   input  rmq_pkg::word_type req_m11,
   input  rmq_pkg::word_type req_m12,
   input  rmq_pkg::word_type req_m20,
   input  rmq_pkg::word_type req_m21,
   input  rmq_pkg::word_type req_m22,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmq_pkg::word_type rsp_quat_x,
   output rmq_pkg::word_type rsp_quat_y,
   output rmq_pkg::word_type rsp_quat_z,
   output rmq_pkg::word_type rsp_quat_w,
   output logic              rsp_bad_input
);
   import rmq_pkg::*;

   // global advance: hold everything while a shown result is stalled
   logic         en;
   logic         div_v   [QW+1];
   div_bus_type  div_bus [QW+1];
   logic         sq_v    [WORD_BITS+1];
   sqrt_bus_type sq_bus  [WORD_BITS+1];
   word_type     q       [LANES];

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // case choice, sums, magnitudes, squares, divider setup
   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .m00       (req_m00),
      .m01       (req_m01),
      .m02       (req_m02),
      .m10       (req_m10),
      .m11       (req_m11),
      .m12       (req_m12),
      .m20       (req_m20),
      .m21       (req_m21),
      .m22       (req_m22),
      .out_valid (div_v[0]),
      .out_bus   (div_bus[0])
   );

   // one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      rmq_div_step u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_v[k]),
         .in_bus    (div_bus[k]),
         .out_valid (div_v[k+1]),
         .out_bus   (div_bus[k+1])
      );
   end

   // quotient becomes the radicand of the root
   assign sq_v[0]       = div_v[QW];
   assign sq_bus[0].bad = div_bus[QW].bad;
   for (genvar i = 0; i < LANES; i++) begin : g_conv
      assign sq_bus[0].lane[i].neg  = div_bus[QW].lane[i].neg;
      assign sq_bus[0].lane[i].ovf  = div_bus[QW].lane[i].ovf;
      assign sq_bus[0].lane[i].rem  = '0;
      assign sq_bus[0].lane[i].root = '0;
      assign sq_bus[0].lane[i].rad  = div_bus[QW].lane[i].acc;
   end

   // one root digit per stage
   for (genvar k = 0; k < WORD_BITS; k++) begin : g_sqrt
      rmq_sqrt_step u_sqrt (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_v[k]),
         .in_bus    (sq_bus[k]),
         .out_valid (sq_v[k+1]),
         .out_bus   (sq_bus[k+1])
      );
   end

   // rounding, saturation and output register
   rmq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_v[WORD_BITS]),
      .in_bus    (sq_bus[WORD_BITS]),
      .out_valid (rsp_valid),
      .out_q     (q),
      .out_bad   (rsp_bad_input)
   );

   assign rsp_quat_x = q[0];
   assign rsp_quat_y = q[1];
   assign rsp_quat_z = q[2];
   assign rsp_quat_w = q[3];

endmodule

/* rtl/core/rmq_checker.sv */
// rmq_checker: port-level checks for rotation_matrix_to_quaternion, bound
// to the top level; depends on rmq_pkg
module rmq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rmq_pkg::word_type rsp_quat_x,
   input rmq_pkg::word_type rsp_quat_y,
   input rmq_pkg::word_type rsp_quat_z,
   input rmq_pkg::word_type rsp_quat_w,
   input logic              rsp_bad_input
);
   import rmq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_quat_x) && $stable(rsp_quat_y)
         && $stable(rsp_quat_z) && $stable(rsp_quat_w) && $stable(rsp_bad_input))
      else $error("rsp payload changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_input |-> rsp_quat_x == '0 && rsp_quat_y == '0
         && rsp_quat_z == '0 && rsp_quat_w == '0)
      else $error("bad_input item with nonzero components");

   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a stalled rsp item");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_quat_x    (rsp_quat_x),
   .rsp_quat_y    (rsp_quat_y),
   .rsp_quat_z    (rsp_quat_z),
   .rsp_quat_w    (rsp_quat_w),
   .rsp_bad_input (rsp_bad_input)
);

/* tb/sv/testbench.sv */
// testbench: self-checking bench for rotation_matrix_to_quaternion
// depends on rmq_pkg and the block; checks every result against a built-in predictor
module testbench;
   import rmq_pkg::*;

   typedef struct {
      word_type m [9];
   } matrix_item;

   typedef struct {
      word_type x, y, z, w;
      logic     bad;
   } quat_result;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 80;

   logic     clock, reset;
   logic     req_valid, req_stall;
   word_type req_m [9];
   logic     rsp_valid, rsp_stall;
   word_type rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   logic     rsp_bad_input;

   rotation_matrix_to_quaternion DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_m00(req_m[0]), .req_m01(req_m[1]), .req_m02(req_m[2]),
      .req_m10(req_m[3]), .req_m11(req_m[4]), .req_m12(req_m[5]),
      .req_m20(req_m[6]), .req_m21(req_m[7]), .req_m22(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_quat_x(rsp_quat_x), .rsp_quat_y(rsp_quat_y),
      .rsp_quat_z(rsp_quat_z), .rsp_quat_w(rsp_quat_w),
      .rsp_bad_input(rsp_bad_input)
   );

   matrix_item pending_matrices [$];
   quat_result expected_quats [$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   bit         taken = 0;

   // rounded, saturated v * 2^(F-1) / sqrt(t * 2^F), found bit by bit
   function automatic word_type scaled_component(longint v, longint t);
      logic [127:0] rhs, lhs;
      longint mag, cap, n, c, odd;
      bit neg;
      neg = v < 0;
      mag = neg ? -v : v;
      cap = neg ? (longint'(1) << (WORD_BITS - 1)) : (longint'(1) << (WORD_BITS - 1)) - 1;
      rhs = (128'(mag) * 128'(mag)) << FRAC_BITS;
      n = 0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         c = n | (longint'(1) << b);
         if (c <= cap) begin
            odd = 2 * c - 1;
            lhs = 128'(odd) * 128'(odd) * 128'(t);
            if (lhs <= rhs) n = c;
         end
      end
      return word_type'(neg ? -n : n);
   endfunction

   function automatic quat_result quat_from_matrix(matrix_item mi);
      longint e [9];
      longint one, t;
      longint c [4];
      quat_result r;
      for (int i = 0; i < 9; i++) e[i] = longint'(mi.m[i]);
      one = longint'(1) << FRAC_BITS;
      // branch on sign of m22, then on the diagonal comparison
      if (e[8] < 0) begin
         if (e[0] > e[4]) begin
            t = one + e[0] - e[4] - e[8];
            c[0] = t; c[1] = e[1] + e[3]; c[2] = e[6] + e[2]; c[3] = e[5] - e[7];
         end else begin
            t = one - e[0] + e[4] - e[8];
            c[0] = e[1] + e[3]; c[1] = t; c[2] = e[5] + e[7]; c[3] = e[6] - e[2];
         end
      end else begin
         if (e[0] < -e[4]) begin
            t = one - e[0] - e[4] + e[8];
            c[0] = e[6] + e[2]; c[1] = e[5] + e[7]; c[2] = t; c[3] = e[1] - e[3];
         end else begin
            t = one + e[0] + e[4] + e[8];
            c[0] = e[5] - e[7]; c[1] = e[6] - e[2]; c[2] = e[1] - e[3]; c[3] = t;
         end
      end
      if (t <= 0) begin
         r.x = '0; r.y = '0; r.z = '0; r.w = '0; r.bad = 1'b1;
      end else begin
         r.x = scaled_component(c[0], t);
         r.y = scaled_component(c[1], t);
         r.z = scaled_component(c[2], t);
         r.w = scaled_component(c[3], t);
         r.bad = 1'b0;
      end
      return r;
   endfunction

   function automatic word_type to_fixed(real v);
      real s;
      s = v * (1 << FRAC_BITS);
      s = (s >= 0.0) ? s + 0.5 : s - 0.5;
      if (s > 32767.0) s = 32767.0;
      if (s < -32768.0) s = -32768.0;
      return word_type'($rtoi(s));
   endfunction

   // a true rotation from a random quaternion, sometimes with a little noise
   function automatic matrix_item random_rotation();
      real qx, qy, qz, qw, nrm;
      real r [9];
      matrix_item mi;
      qx = ($itor($urandom_range(0, 2000)) - 1000.0) / 1000.0;
      qy = ($itor($urandom_range(0, 2000)) - 1000.0) / 1000.0;
      qz = ($itor($urandom_range(0, 2000)) - 1000.0) / 1000.0;
      qw = ($itor($urandom_range(0, 2000)) - 1000.0) / 1000.0;
      nrm = $sqrt(qx * qx + qy * qy + qz * qz + qw * qw);
      if (nrm < 0.001) begin
         qw = 1.0; nrm = 1.0;
      end
      qx = qx / nrm; qy = qy / nrm; qz = qz / nrm; qw = qw / nrm;
      r[0] = 1.0 - 2.0 * (qy * qy + qz * qz);
      r[1] = 2.0 * (qx * qy - qz * qw);
      r[2] = 2.0 * (qx * qz + qy * qw);
      r[3] = 2.0 * (qx * qy + qz * qw);
      r[4] = 1.0 - 2.0 * (qx * qx + qz * qz);
      r[5] = 2.0 * (qy * qz - qx * qw);
      r[6] = 2.0 * (qx * qz - qy * qw);
      r[7] = 2.0 * (qy * qz + qx * qw);
      r[8] = 1.0 - 2.0 * (qx * qx + qy * qy);
      for (int i = 0; i < 9; i++) begin
         mi.m[i] = to_fixed(r[i]);
         if ($urandom_range(0, 9) == 0)
            mi.m[i] = mi.m[i] + word_type'(int'($urandom_range(0, 6)) - 3);
      end
      return mi;
   endfunction

   function automatic matrix_item diag_matrix(word_type a, word_type b, word_type c);
      matrix_item mi;
      for (int i = 0; i < 9; i++) mi.m[i] = '0;
      mi.m[0] = a; mi.m[4] = b; mi.m[8] = c;
      return mi;
   endfunction

   task automatic report_mismatch(string what, word_type got, word_type want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // clock and the single reset pulse
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      req_valid = 0;
      rsp_stall = 0;
      for (int i = 0; i < 9; i++) req_m[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 0;
   end

   // stimulus: directed corners first, then rotations mixed with raw noise
   initial begin
      matrix_item mi;
      word_type one_w;
      one_w = word_type'(1 << FRAC_BITS);
      // identity, and each of the four branches with clean diagonals
      pending_matrices.push_back(diag_matrix(one_w, one_w, one_w));
      pending_matrices.push_back(diag_matrix(-one_w, -one_w, one_w));
      pending_matrices.push_back(diag_matrix(one_w, -one_w, -one_w));
      pending_matrices.push_back(diag_matrix(-one_w, one_w, -one_w));
      // m22 at the sign boundary, equal diagonals, m00 == -m11
      pending_matrices.push_back(diag_matrix(one_w, one_w, '0));
      pending_matrices.push_back(diag_matrix(word_type'(100), word_type'(100), -one_w));
      pending_matrices.push_back(diag_matrix(word_type'(5000), word_type'(-5000), one_w));
      pending_matrices.push_back(diag_matrix(word_type'(-5000), word_type'(4999), '0));
      // all entries at the extremes, then an all-zero matrix
      for (int i = 0; i < 9; i++) mi.m[i] = word_type'(16'h8000);
      pending_matrices.push_back(mi);
      for (int i = 0; i < 9; i++) mi.m[i] = word_type'(16'h7fff);
      pending_matrices.push_back(mi);
      for (int i = 0; i < 9; i++) mi.m[i] = (i % 2) ? word_type'(16'h7fff) : word_type'(16'h8000);
      pending_matrices.push_back(mi);
      for (int i = 0; i < 9; i++) mi.m[i] = (i % 2) ? word_type'(16'h8000) : word_type'(16'h7fff);
      pending_matrices.push_back(mi);
      for (int i = 0; i < 9; i++) mi.m[i] = '0;
      pending_matrices.push_back(mi);
      // huge off-diagonal terms, with extreme or near-zero diagonals
      mi = diag_matrix(word_type'(16'h8000), word_type'(16'h8000), word_type'(16'h8000));
      mi.m[1] = word_type'(16'h7fff); mi.m[3] = word_type'(16'h7fff);
      mi.m[5] = word_type'(16'h8000); mi.m[7] = word_type'(16'h7fff);
      pending_matrices.push_back(mi);
      mi = diag_matrix('0, '0, word_type'(-1));
      mi.m[2] = word_type'(16'h7fff); mi.m[6] = word_type'(16'h7fff);
      pending_matrices.push_back(mi);
      for (int k = 0; k < 1850; k++) begin
         if ($urandom_range(0, 9) < 6) begin
            pending_matrices.push_back(random_rotation());
         end else begin
            for (int i = 0; i < 9; i++) mi.m[i] = word_type'($urandom_range(0, 16'hffff));
            pending_matrices.push_back(mi);
         end
      end
   end

   // driver: bursts of items separated by random gaps, changes on the falling edge
   int burst_left = 4;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset && (taken || !req_valid)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_matrices.size() > 0) begin
            matrix_item mi;
            mi = pending_matrices.pop_front();
            for (int i = 0; i < 9; i++) req_m[i] <= mi.m[i];
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
      taken = 0;
   end

   // receiver stall: phases of no stall, random stall, and long stall runs
   int stall_phase_left = 0;
   int stall_mode = 0;
   always @(negedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_phase_left = $urandom_range(20, 200);
      end
      stall_phase_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 35);
         default: rsp_stall <= ((stall_phase_left % 16) < 9);
      endcase
   end

   // monitor: check results against the oldest expectation, then record new items
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_quats.size() == 0) begin
               report_mismatch("unexpected result", rsp_quat_x, '0);
            end else begin
               quat_result want;
               want = expected_quats.pop_front();
               if (rsp_quat_x !== want.x) report_mismatch("quat_x", rsp_quat_x, want.x);
               if (rsp_quat_y !== want.y) report_mismatch("quat_y", rsp_quat_y, want.y);
               if (rsp_quat_z !== want.z) report_mismatch("quat_z", rsp_quat_z, want.z);
               if (rsp_quat_w !== want.w) report_mismatch("quat_w", rsp_quat_w, want.w);
               if (rsp_bad_input !== want.bad)
                  report_mismatch("bad_input", word_type'(rsp_bad_input), word_type'(want.bad));
            end
         end
         if (req_valid && !req_stall) begin
            matrix_item mi;
            for (int i = 0; i < 9; i++) mi.m[i] = req_m[i];
            expected_quats.push_back(quat_from_matrix(mi));
            taken = 1;
         end
      end
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // end of run: all items sent, all results back, then a drain period
   initial begin
      @(negedge reset);
      wait (pending_matrices.size() == 0 && !req_valid && expected_quats.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_quats.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
